>>> sv/nrcm_pkg.sv
// ----------------------------------------------------------------------------
// nrcm_pkg
// Shared widths, register map, configuration type and the operation codes of
// the shared accumulator unit of the nearest-neighbor rate converter.
// ----------------------------------------------------------------------------
package nrcm_pkg;

  localparam int RATE_W     = 19;          // rate register width
  localparam int CFG_CH_W   = 4;           // dst_channels register width
  localparam int SAMP_W     = 16;          // source sample width
  localparam int OUT_W      = 17;          // Q1.16 destination sample width
  localparam int CHAN_OUT_W = 3;           // channel index width on the output
  localparam int ACC_W      = 24;          // phase / length accumulator width
  localparam int STEP_W     = RATE_W + 1;  // width of 2*rate
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [RATE_W-1:0]   RATE_RST  = 19'd48000;
  localparam logic [CFG_CH_W-1:0] CHANS_RST = 4'd2;

  typedef enum logic [1:0] {
    REG_SRC_RATE  = 2'd0,
    REG_DST_RATE  = 2'd1,
    REG_SRC_MONO  = 2'd2,
    REG_DST_CHANS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0]   src_rate;
    logic [RATE_W-1:0]   dst_rate;
    logic                src_is_mono;
    logic [CFG_CH_W-1:0] dst_channels;
  } cfg_t;

  typedef enum logic [2:0] {
    ALU_LOAD_OFS,    // src - dst
    ALU_LOAD_PHASE,  // -dst
    ALU_LOAD_ACC,    // phase (+ offset on a final frame)
    ALU_STEP,        // acc + 2*src
    ALU_RETIRE,      // acc - 2*dst
    ALU_DIV_TRY,     // partial remainder - 2*src
    ALU_DIV_FIX      // 2*src - 1 - remainder
  } alu_op_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] phase;
    logic signed [ACC_W-1:0] offset;
    logic [RATE_W-1:0]       src;
    logic [RATE_W-1:0]       dst;
    logic                    fin;
    logic [STEP_W:0]         part;
    logic [STEP_W-1:0]       rem;
  } alu_src_t;

endpackage

>>> sv/nrcm_in_if.sv
// ----------------------------------------------------------------------------
// nrcm_in_if
// Source frame channel: valid/ready handshake with one stereo frame.
// ----------------------------------------------------------------------------
interface nrcm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [nrcm_pkg::SAMP_W-1:0]  left_in;
  logic signed [nrcm_pkg::SAMP_W-1:0]  right_in;
  logic                                final_frame;

  modport source (output valid, left_in, right_in, final_frame, input ready);
  modport sink   (input valid, left_in, right_in, final_frame, output ready);
endinterface

>>> sv/nrcm_out_if.sv
// ----------------------------------------------------------------------------
// nrcm_out_if
// Destination sample channel: valid/ready handshake with one Q1.16 sample.
// ----------------------------------------------------------------------------
interface nrcm_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [nrcm_pkg::OUT_W-1:0]       sample_out;
  logic [nrcm_pkg::CHAN_OUT_W-1:0]         channel_out;
  logic                                    run_last;
  logic                                    overflow;

  modport source (output valid, sample_out, channel_out, run_last, overflow,
                  input ready);
  modport sink   (input valid, sample_out, channel_out, run_last, overflow,
                  output ready);
endinterface

>>> sv/nrcm_apb_regs.sv
// ----------------------------------------------------------------------------
// nrcm_apb_regs
// APB register bank: source rate, destination rate, mono flag, channel count.
// ----------------------------------------------------------------------------
module nrcm_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrcm_pkg::APB_AW-1:0]   paddr,
  input  logic [nrcm_pkg::APB_DW-1:0]   pwdata,
  output logic [nrcm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output nrcm_pkg::cfg_t                cfg
);

  nrcm_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = nrcm_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_rate     <= nrcm_pkg::RATE_RST;
      cfg.dst_rate     <= nrcm_pkg::RATE_RST;
      cfg.src_is_mono  <= 1'b0;
      cfg.dst_channels <= nrcm_pkg::CHANS_RST;
    end else if (wr_en) begin
      unique case (idx)
        nrcm_pkg::REG_SRC_RATE:  cfg.src_rate     <= pwdata[nrcm_pkg::RATE_W-1:0];
        nrcm_pkg::REG_DST_RATE:  cfg.dst_rate     <= pwdata[nrcm_pkg::RATE_W-1:0];
        nrcm_pkg::REG_SRC_MONO:  cfg.src_is_mono  <= pwdata[0];
        nrcm_pkg::REG_DST_CHANS: cfg.dst_channels <= pwdata[nrcm_pkg::CFG_CH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      nrcm_pkg::REG_SRC_RATE:  prdata = nrcm_pkg::APB_DW'(cfg.src_rate);
      nrcm_pkg::REG_DST_RATE:  prdata = nrcm_pkg::APB_DW'(cfg.dst_rate);
      nrcm_pkg::REG_SRC_MONO:  prdata = nrcm_pkg::APB_DW'(cfg.src_is_mono);
      nrcm_pkg::REG_DST_CHANS: prdata = nrcm_pkg::APB_DW'(cfg.dst_channels);
    endcase
  end

endmodule

>>> sv/nrcm_alu.sv
// ----------------------------------------------------------------------------
// nrcm_alu
// Shared accumulator adder: picks two operands by operation code and adds.
// Serves accumulator loads, phase steps, retirement and remainder steps.
// ----------------------------------------------------------------------------
module nrcm_alu (
  input  nrcm_pkg::alu_op_t                    op,
  input  nrcm_pkg::alu_src_t                   opnd,
  output logic signed [nrcm_pkg::ACC_W-1:0]    sum
);

  localparam int W = nrcm_pkg::ACC_W;

  logic signed [W-1:0] op_a;
  logic signed [W-1:0] op_b;
  logic [W-1:0]        src_x;
  logic [W-1:0]        dst_x;
  logic [W-1:0]        step_x;
  logic [W-1:0]        dstep_x;

  assign src_x   = W'(opnd.src);
  assign dst_x   = W'(opnd.dst);
  assign step_x  = W'({opnd.src, 1'b0});
  assign dstep_x = W'({opnd.dst, 1'b0});

  always_comb begin
    unique case (op)
      nrcm_pkg::ALU_LOAD_OFS: begin
        op_a = src_x;
        op_b = -dst_x;
      end
      nrcm_pkg::ALU_LOAD_PHASE: begin
        op_a = '0;
        op_b = -dst_x;
      end
      nrcm_pkg::ALU_LOAD_ACC: begin
        op_a = opnd.phase;
        op_b = opnd.fin ? opnd.offset : '0;
      end
      nrcm_pkg::ALU_STEP: begin
        op_a = opnd.acc;
        op_b = step_x;
      end
      nrcm_pkg::ALU_RETIRE: begin
        op_a = opnd.acc;
        op_b = -dstep_x;
      end
      nrcm_pkg::ALU_DIV_TRY: begin
        op_a = W'(opnd.part);
        op_b = -step_x;
      end
      nrcm_pkg::ALU_DIV_FIX: begin
        op_a = step_x;
        op_b = ~W'(opnd.rem);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = op_a + op_b;

endmodule

>>> sv/nrcm_seq.sv
// ----------------------------------------------------------------------------
// nrcm_seq
// Sequencer: walks one source frame through accumulator load, per-frame
// decision, per-channel emission and the skip-ahead remainder after a cut.
// Holds the phase state and the output register.
// ----------------------------------------------------------------------------
module nrcm_seq #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_RUN      = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nrcm_pkg::cfg_t                       cfg,
  input  logic signed [nrcm_pkg::ACC_W-1:0]    alu_sum,
  output nrcm_pkg::alu_op_t                    alu_op,
  output nrcm_pkg::alu_src_t                   alu_src,
  nrcm_in_if.sink                              frames,
  nrcm_out_if.source                           samples
);

  localparam int ACC_W  = nrcm_pkg::ACC_W;
  localparam int RATE_W = nrcm_pkg::RATE_W;
  localparam int STEP_W = nrcm_pkg::STEP_W;
  localparam int CCW    = nrcm_pkg::CFG_CH_W;
  localparam int SAMP_W = nrcm_pkg::SAMP_W;
  localparam int OUT_W  = nrcm_pkg::OUT_W;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RUN_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int BIT_W  = $clog2(ACC_W);

  typedef enum logic [3:0] {
    S_IDLE, S_OFS, S_PHS, S_LOAD, S_CHK, S_ADV, S_EMIT, S_CUT, S_DIV, S_FIX,
    S_DONE
  } state_t;

  state_t                     state;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    phase;
  logic signed [ACC_W-1:0]    offset;
  logic                       pending;
  logic                       force_frame;
  logic                       cutting;
  logic [RATE_W-1:0]          s_q;
  logic [RATE_W-1:0]          d_q;
  logic [CCW-1:0]             chans_m1_q;
  logic                       fin_q;
  logic signed [SAMP_W-1:0]   left_q;
  logic signed [SAMP_W-1:0]   right_q;
  logic signed [OUT_W-1:0]    mix_q;
  logic [CH_W-1:0]            chan;
  logic [RUN_W-1:0]           run_cnt;
  logic [ACC_W-1:0]           dvd;
  logic [STEP_W-1:0]          rem;
  logic [BIT_W-1:0]           bit_cnt;

  logic                       out_valid;
  logic signed [OUT_W-1:0]    out_sample;
  logic [nrcm_pkg::CHAN_OUT_W-1:0] out_chan;
  logic                       out_last;
  logic                       out_ovf;

  logic [CCW-1:0]             chans_m1;
  logic signed [SAMP_W-1:0]   right_sel;
  logic                       want;
  logic                       slot_free;
  logic                       last_chan;
  logic                       run_full;
  logic                       res_last;
  logic                       res_cut;
  logic signed [OUT_W-1:0]    ch_val;
  logic [STEP_W:0]            part;

  // clamp the channel count into 1..MAX_CHANNELS, kept as count minus one
  always_comb begin
    priority if (cfg.dst_channels == '0) begin
      chans_m1 = '0;
    end else if ({1'b0, cfg.dst_channels} > (CCW+1)'(MAX_CHANNELS)) begin
      chans_m1 = CCW'(MAX_CHANNELS - 1);
    end else begin
      chans_m1 = cfg.dst_channels - CCW'(1);
    end
  end

  assign right_sel = cfg.src_is_mono ? frames.left_in : frames.right_in;

  // a frame is due while phase < 0; on the final input while length <= 0
  assign want = fin_q ? (acc[ACC_W-1] || (acc == '0)) : acc[ACC_W-1];

  assign slot_free = !out_valid || samples.ready;
  assign last_chan = (CCW'(chan) == chans_m1_q);
  assign run_full  = (run_cnt == RUN_W'(MAX_RUN - 1));
  assign res_last  = last_chan ? (run_full || !want) : run_full;
  assign res_cut   = last_chan ? (run_full && want) : run_full;

  always_comb begin
    if (chans_m1_q == '0) begin
      ch_val = mix_q;
    end else if (chan[0]) begin
      ch_val = {right_q, 1'b0};
    end else begin
      ch_val = {left_q, 1'b0};
    end
  end

  assign part = {rem, dvd[ACC_W-1]};

  always_comb begin
    alu_src.acc    = acc;
    alu_src.phase  = phase;
    alu_src.offset = offset;
    alu_src.src    = s_q;
    alu_src.dst    = d_q;
    alu_src.fin    = fin_q;
    alu_src.part   = part;
    alu_src.rem    = rem;
    unique case (state)
      S_OFS:   alu_op = nrcm_pkg::ALU_LOAD_OFS;
      S_PHS:   alu_op = nrcm_pkg::ALU_LOAD_PHASE;
      S_LOAD:  alu_op = nrcm_pkg::ALU_LOAD_ACC;
      S_DIV:   alu_op = nrcm_pkg::ALU_DIV_TRY;
      S_FIX:   alu_op = nrcm_pkg::ALU_DIV_FIX;
      S_DONE:  alu_op = nrcm_pkg::ALU_RETIRE;
      default: alu_op = nrcm_pkg::ALU_STEP;
    endcase
  end

  assign frames.ready        = (state == S_IDLE);
  assign samples.valid       = out_valid;
  assign samples.sample_out  = out_sample;
  assign samples.channel_out = out_chan;
  assign samples.run_last    = out_last;
  assign samples.overflow    = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= '0;
      offset      <= '0;
      pending     <= 1'b1;
      force_frame <= 1'b0;
      cutting     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // drop valid after a transfer unless the next sample loads right away
      if (samples.ready && !(state == S_EMIT && slot_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (frames.valid) begin
            s_q         <= (cfg.src_rate == '0) ? RATE_W'(1) : cfg.src_rate;
            d_q         <= (cfg.dst_rate == '0) ? RATE_W'(1) : cfg.dst_rate;
            chans_m1_q  <= chans_m1;
            fin_q       <= frames.final_frame;
            left_q      <= frames.left_in;
            right_q     <= right_sel;
            mix_q       <= OUT_W'(frames.left_in) + OUT_W'(right_sel);
            force_frame <= pending;
            cutting     <= 1'b0;
            run_cnt     <= '0;
            state       <= pending ? S_OFS : S_LOAD;
          end
        end
        S_OFS: begin
          offset <= alu_sum;
          state  <= S_PHS;
        end
        S_PHS: begin
          phase   <= alu_sum;
          pending <= 1'b0;
          state   <= S_LOAD;
        end
        S_LOAD: begin
          acc   <= alu_sum;
          state <= S_CHK;
        end
        S_CHK: begin
          force_frame <= 1'b0;
          state       <= (force_frame || want) ? S_ADV : S_DONE;
        end
        S_ADV: begin
          // advance past the frame about to go out; a cut ends here
          acc   <= alu_sum;
          chan  <= '0;
          state <= cutting ? S_CUT : S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_sample <= ch_val;
            out_chan   <= nrcm_pkg::CHAN_OUT_W'(chan);
            out_last   <= res_last;
            out_ovf    <= res_cut;
            run_cnt    <= run_cnt + RUN_W'(1);
            if (!last_chan) begin
              chan <= chan + CH_W'(1);
              if (run_full) begin
                state <= S_CUT;
              end
            end else if (!want) begin
              state <= S_DONE;
            end else begin
              cutting <= run_full;
              state   <= S_ADV;
            end
          end
        end
        S_CUT: begin
          // skip the rest of this source frame: remainder of ~acc by 2*src
          if (!fin_q && acc[ACC_W-1]) begin
            dvd     <= ~acc;
            rem     <= '0;
            bit_cnt <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          rem <= alu_sum[ACC_W-1] ? part[STEP_W-1:0] : alu_sum[STEP_W-1:0];
          dvd <= dvd << 1;
          if (bit_cnt == BIT_W'(ACC_W - 1)) begin
            state <= S_FIX;
          end else begin
            bit_cnt <= bit_cnt + BIT_W'(1);
          end
        end
        S_FIX: begin
          acc   <= alu_sum;
          state <= S_DONE;
        end
        S_DONE: begin
          if (fin_q) begin
            phase   <= '0;
            offset  <= '0;
            pending <= 1'b1;
          end else begin
            phase <= alu_sum;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/nearest_resample_channel_mix.sv
// ----------------------------------------------------------------------------
// nearest_resample_channel_mix
// Nearest-neighbor sample rate converter with channel mixing. Source frames
// in, Q1.16 destination samples out, rates and channel layout over APB.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake        Transfer
//  --------  ----  ---------------  -----------------------------------------
//  frames    in    valid / ready    left_in, right_in, final_frame
//  samples   out   valid / ready    sample_out, channel_out, run_last, overflow
//  apb       in    psel / penable   rate, mono and channel count registers
//
//  Sequence: a frame transfer starts with accumulator setup (offset and phase
//  loads first on the first frame of a buffer), then per destination frame an
//  advance step and one emission step per destination channel, then a phase
//  retirement. A non-final run cut at MAX_RUN adds a remainder search,
//  one bit per cycle through the shared adder. Every accumulator and
//  remainder add goes through that one adder.
//  Reset: synchronous, active high; registers return to their defaults and
//  the next frame starts a new buffer. Stalls on samples hold the emission
//  step; frames are not taken until the current one is fully retired.
//
// Phase tracking: phase = 2*j*S - (2*i+1)*D decides whether destination frame
// j belongs to source frame i. Length error differs from phase by a constant
// offset inside a buffer, so only phase and offset are stored; on a final
// frame the accumulator is loaded with phase + offset instead.
// ----------------------------------------------------------------------------
module nearest_resample_channel_mix #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_RUN      = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrcm_pkg::APB_AW-1:0]   paddr,
  input  logic [nrcm_pkg::APB_DW-1:0]   pwdata,
  output logic [nrcm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  nrcm_in_if.sink                       frames,
  nrcm_out_if.source                    samples
);

  nrcm_pkg::cfg_t                       cfg;
  nrcm_pkg::alu_op_t                    alu_op;
  nrcm_pkg::alu_src_t                   alu_src;
  logic signed [nrcm_pkg::ACC_W-1:0]    alu_sum;

  // register bank; values are sampled by the sequencer at each frame transfer
  nrcm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the one adder shared by every accumulator and remainder step
  nrcm_alu u_alu (
    .op   (alu_op),
    .opnd (alu_src),
    .sum  (alu_sum)
  );

  // sequencer with phase state and output register
  nrcm_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_RUN      (MAX_RUN)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .alu_sum (alu_sum),
    .alu_op  (alu_op),
    .alu_src (alu_src),
    .frames  (frames),
    .samples (samples)
  );

endmodule
